// ===== sv/quoted_escape_token_parser_macros.svh =====
// Assertion macros for the quoted escape token parser.
// Depends on clk_i and rst_ni being in scope where a macro is used.
`ifndef QUOTED_ESCAPE_TOKEN_PARSER_MACROS_SVH
`define QUOTED_ESCAPE_TOKEN_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge out of reset.
`define QETP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qetp: assertion failed");

// Condition must never be seen at a clock edge out of reset.
`define QETP_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("qetp: forbidden condition seen");

`else

`define QETP_ASSERT(lbl, prop)
`define QETP_NEVER(lbl, cond)

`endif

`endif

// ===== sv/qetp_pkg.sv =====
// Shared types, codes, character constants and decode helpers for the parser.
// No dependencies.
package qetp_pkg;

  localparam int unsigned MAX_TOKEN_LEN = 255;
  localparam int unsigned QUEUE_DEPTH   = 4;

  typedef logic [7:0] ch_t;

  typedef enum logic [2:0] {
    ST_BYTE      = 3'd0,
    ST_TOKEN_END = 3'd1,
    ST_NO_TOKEN  = 3'd2,
    ST_UNCLOSED  = 3'd3,
    ST_ZERO_ESC  = 3'd4,
    ST_TOO_LONG  = 3'd5,
    ST_EMPTY_HEX = 3'd6
  } status_e;

  typedef struct packed {
    ch_t     data;
    status_e status;
  } res_t;

  // One queue entry: the results of one character, one or two of them.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  localparam ch_t CH_NUL    = 8'h00;
  localparam ch_t CH_SPACE  = 8'h20;
  localparam ch_t CH_DQUOTE = 8'h22;
  localparam ch_t CH_BSLASH = 8'h5C;
  localparam ch_t CH_ZERO   = 8'h30;
  localparam ch_t CH_SEVEN  = 8'h37;
  localparam ch_t CH_NINE   = 8'h39;
  localparam ch_t CH_UP_A   = 8'h41;
  localparam ch_t CH_UP_F   = 8'h46;
  localparam ch_t CH_LO_A   = 8'h61;
  localparam ch_t CH_LO_B   = 8'h62;
  localparam ch_t CH_LO_F   = 8'h66;
  localparam ch_t CH_LO_N   = 8'h6E;
  localparam ch_t CH_LO_R   = 8'h72;
  localparam ch_t CH_LO_T   = 8'h74;
  localparam ch_t CH_LO_V   = 8'h76;
  localparam ch_t CH_LO_X   = 8'h78;

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_val(input ch_t c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // {hit, byte} for the single-letter escapes
  function automatic logic [8:0] esc_letter(input ch_t c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      CH_LO_N: r = {1'b1, 8'd10};
      CH_LO_T: r = {1'b1, 8'd9};
      CH_LO_R: r = {1'b1, 8'd13};
      CH_LO_A: r = {1'b1, 8'd7};
      CH_LO_B: r = {1'b1, 8'd8};
      CH_LO_F: r = {1'b1, 8'd12};
      CH_LO_V: r = {1'b1, 8'd11};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/qetp_if.sv =====
// Valid/ready channel interfaces for characters in and results out.
// Depends on qetp_pkg.
interface qetp_in_if;
  logic          valid;
  logic          ready;
  qetp_pkg::ch_t ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface qetp_out_if;
  logic          valid;
  logic          ready;
  qetp_pkg::ch_t data;
  logic [2:0]    status;
  logic          last;

  modport source (output valid, output data, output status, output last, input ready);
  modport sink   (input valid, input data, input status, input last, output ready);
endinterface

// ===== sv/quoted_escape_token_parser.sv =====
// A character's first result goes through the result queue and then the output register.
// Throughput: one character per cycle while the result queue has room; a character with two
//   results (an escape byte closed by the next character) holds the output stage for both.
// The four-entry result queue between the front and back end absorbs output stalls.
// Reset (rst_ni, asynchronous, active low) returns to between tokens with an empty queue.
//
// Top level of the command-line tokenizer. Depends on qetp_pkg, the channel
// interfaces, qetp_front, qetp_queue and qetp_back.
module quoted_escape_token_parser #(
  parameter int unsigned MaxTokenLen = qetp_pkg::MAX_TOKEN_LEN,
  parameter int unsigned QueueDepth  = qetp_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qetp_in_if.sink    in_i,
  qetp_out_if.source out_o
);
  import qetp_pkg::*;

  // Front end -> queue: one entry per character that yields results.
  // A character yields nothing while quotes open, escapes build up,
  // spaces are skipped or a line is being discarded.
  logic   push;
  logic   full;
  entry_t push_entry;

  // Queue -> back end: the head entry, popped when the output stage frees up.
  logic   head_vld;
  logic   pop;
  entry_t head_entry;

  // Tokenizer state machine; its ready is simply "queue not full", so a
  // waiting result never blocks the next character while space remains.
  qetp_front #(
    .MaxTokenLen (MaxTokenLen)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // Decoupling queue.
  qetp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .vld_o   (head_vld),
    .entry_o (head_entry)
  );

  // Output stage: splits two-result entries and sets last on the final one.
  qetp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (head_vld),
    .entry_i (head_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== sv/qetp_front.sv =====
// Front end: takes one character per request, runs the tokenizer state machine
// and pushes the results of the character into the queue. Depends on qetp_pkg.
`include "quoted_escape_token_parser_macros.svh"

module qetp_front #(
  parameter int unsigned MaxTokenLen = qetp_pkg::MAX_TOKEN_LEN
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  qetp_in_if.sink          in_i,
  input  logic             full_i,
  output logic             push_o,
  output qetp_pkg::entry_t entry_o
);
  import qetp_pkg::*;

  localparam int unsigned LenW = $clog2(MaxTokenLen + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(MaxTokenLen);

  typedef enum logic [7:0] {
    M_SKIP    = 8'b0000_0001,
    M_TOKEN   = 8'b0000_0010,
    M_QUOTE   = 8'b0000_0100,
    M_ESC     = 8'b0000_1000,
    M_HEXF    = 8'b0001_0000,
    M_HEX     = 8'b0010_0000,
    M_OCT     = 8'b0100_0000,
    M_DISCARD = 8'b1000_0000
  } mode_e;

  mode_e           mode_q, mode_d;
  ch_t             ev_q, ev_d;
  logic [1:0]      od_q, od_d;
  logic [LenW-1:0] len_q, len_d;

  ch_t        ch;
  logic       take;
  logic       do_token, do_quote, from_finish;
  logic       p_vld, q_vld, o_vld;
  res_t       p_res, q_res, o_res;
  logic [4:0] hex;
  logic [8:0] esc;
  ch_t        ev_oct;
  logic [1:0] od_inc;
  logic       is_oct;

  assign ch     = in_i.ch;
  assign take   = in_i.valid && in_i.ready;
  assign hex    = hex_val(ch);
  assign esc    = esc_letter(ch);
  assign ev_oct = {ev_q[4:0], ch[2:0]};
  assign od_inc = od_q + 2'd1;
  assign is_oct = (ch >= CH_ZERO) && (ch <= CH_SEVEN);

  // an error ends the line unless it was caused by the end of line itself
  function automatic mode_e fail_mode(input ch_t c);
    mode_e m;
    m = M_DISCARD;
    if (c == CH_NUL) begin
      m = M_SKIP;
    end
    return m;
  endfunction

  always_comb begin
    mode_d      = mode_q;
    ev_d        = ev_q;
    od_d        = od_q;
    len_d       = len_q;
    do_token    = 1'b0;
    do_quote    = 1'b0;
    from_finish = 1'b0;
    p_vld       = 1'b0;
    q_vld       = 1'b0;
    o_vld       = 1'b0;
    p_res       = '{data: '0, status: ST_BYTE};
    q_res       = '{data: '0, status: ST_BYTE};
    o_res       = '{data: '0, status: ST_BYTE};

    if (take) begin
      case (mode_q)
        M_SKIP: begin
          if (ch == CH_NUL) begin
            p_vld        = 1'b1;
            p_res.status = ST_NO_TOKEN;
          end else if (ch != CH_SPACE) begin
            len_d    = '0;
            mode_d   = M_TOKEN;
            do_token = 1'b1;
          end
        end
        M_TOKEN: do_token = 1'b1;
        M_QUOTE: do_quote = 1'b1;
        M_ESC: begin
          mode_d = M_QUOTE;
          if (ch == CH_NUL) begin
            p_vld        = 1'b1;
            p_res.status = ST_UNCLOSED;
            mode_d       = fail_mode(ch);
            len_d        = '0;
            ev_d         = '0;
            od_d         = '0;
          end else if (esc[8]) begin
            p_vld      = 1'b1;
            p_res.data = esc[7:0];
            len_d      = len_d + LenW'(1);
          end else if (ch == CH_LO_X) begin
            ev_d   = '0;
            mode_d = M_HEXF;
          end else if (is_oct) begin
            ev_d   = {5'd0, ch[2:0]};
            od_d   = 2'd1;
            mode_d = M_OCT;
          end else begin
            p_vld      = 1'b1;
            p_res.data = ch;
            len_d      = len_d + LenW'(1);
          end
        end
        M_HEXF: begin
          if (hex[4]) begin
            ev_d   = {4'd0, hex[3:0]};
            mode_d = M_HEX;
          end else begin
            p_vld        = 1'b1;
            p_res.status = ST_EMPTY_HEX;
            mode_d       = fail_mode(ch);
            len_d        = '0;
            ev_d         = '0;
            od_d         = '0;
          end
        end
        M_HEX: begin
          if (hex[4]) begin
            ev_d = {ev_q[3:0], hex[3:0]};
          end else if (ev_q == '0) begin
            p_vld        = 1'b1;
            p_res.status = ST_ZERO_ESC;
            mode_d       = fail_mode(ch);
            len_d        = '0;
            ev_d         = '0;
            od_d         = '0;
          end else begin
            p_vld       = 1'b1;
            p_res.data  = ev_q;
            len_d       = len_d + LenW'(1);
            ev_d        = '0;
            od_d        = '0;
            mode_d      = M_QUOTE;
            do_quote    = 1'b1;
            from_finish = 1'b1;
          end
        end
        M_OCT: begin
          if (is_oct && od_inc != 2'd3) begin
            ev_d = ev_oct;
            od_d = od_inc;
          end else if ((is_oct && ev_oct == '0) || (!is_oct && ev_q == '0)) begin
            p_vld        = 1'b1;
            p_res.status = ST_ZERO_ESC;
            mode_d       = fail_mode(ch);
            len_d        = '0;
            ev_d         = '0;
            od_d         = '0;
          end else begin
            // third digit closes the escape; any other character also goes on
            p_vld       = 1'b1;
            p_res.data  = is_oct ? ev_oct : ev_q;
            len_d       = len_d + LenW'(1);
            ev_d        = '0;
            od_d        = '0;
            mode_d      = M_QUOTE;
            do_quote    = !is_oct;
            from_finish = !is_oct;
          end
        end
        M_DISCARD: begin
          if (ch == CH_NUL) begin
            mode_d = M_SKIP;
            len_d  = '0;
          end
        end
        default: begin
          mode_d = M_SKIP;
        end
      endcase

      if (do_token) begin
        if (ch == CH_NUL || ch == CH_SPACE) begin
          p_vld        = 1'b1;
          p_res.status = ST_TOKEN_END;
          mode_d       = M_SKIP;
          len_d        = '0;
        end else if (ch == CH_DQUOTE) begin
          mode_d = M_QUOTE;
        end else if (len_d >= LenMax) begin
          p_vld        = 1'b1;
          p_res.status = ST_TOO_LONG;
          mode_d       = fail_mode(ch);
          len_d        = '0;
          ev_d         = '0;
          od_d         = '0;
        end else begin
          p_vld      = 1'b1;
          p_res.data = ch;
          len_d      = len_d + LenW'(1);
        end
      end

      if (do_quote) begin
        if (ch == CH_NUL) begin
          o_vld        = 1'b1;
          o_res.status = ST_UNCLOSED;
          mode_d       = fail_mode(ch);
          len_d        = '0;
          ev_d         = '0;
          od_d         = '0;
        end else if (ch == CH_DQUOTE) begin
          mode_d = M_TOKEN;
        end else if (len_d >= LenMax) begin
          // length is checked at the backslash, not at the escape byte
          o_vld        = 1'b1;
          o_res.status = ST_TOO_LONG;
          mode_d       = fail_mode(ch);
          len_d        = '0;
          ev_d         = '0;
          od_d         = '0;
        end else if (ch == CH_BSLASH) begin
          mode_d = M_ESC;
        end else begin
          o_vld      = 1'b1;
          o_res.data = ch;
          len_d      = len_d + LenW'(1);
        end
        if (from_finish) begin
          q_vld = o_vld;
          q_res = o_res;
        end else begin
          p_vld = o_vld;
          p_res = o_res;
        end
      end
    end
  end

  assign in_i.ready  = !full_i;
  assign push_o      = take && p_vld;
  assign entry_o.two = q_vld;
  assign entry_o.r0  = p_res;
  assign entry_o.r1  = q_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_SKIP;
      ev_q   <= '0;
      od_q   <= '0;
      len_q  <= '0;
    end else begin
      mode_q <= mode_d;
      ev_q   <= ev_d;
      od_q   <= od_d;
      len_q  <= len_d;
    end
  end

  `QETP_ASSERT(a_len_bound, len_q <= LenMax)
  `QETP_ASSERT(a_od_only_oct, (od_q != 2'd0) |-> (mode_q == M_OCT))
  `QETP_ASSERT(a_ev_only_esc, (ev_q != '0) |-> (mode_q == M_HEX || mode_q == M_OCT))

endmodule

// ===== sv/qetp_queue.sv =====
// Short queue of per-character result entries between front and back end.
// Depends on qetp_pkg.
`include "quoted_escape_token_parser_macros.svh"

module qetp_queue #(
  parameter int unsigned Depth = qetp_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  qetp_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             vld_o,
  output qetp_pkg::entry_t entry_o
);
  import qetp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign vld_o   = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `QETP_ASSERT(a_cnt_bound, cnt_q <= CntFull)
  `QETP_NEVER(a_push_lost, push_i && full_o)
  `QETP_NEVER(a_pop_empty, pop_i && !vld_o)

endmodule

// ===== sv/qetp_back.sv =====
// Back end: pops queue entries and hands out their results one per request,
// marking the last result of each character. Depends on qetp_pkg.
`include "quoted_escape_token_parser_macros.svh"

module qetp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  qetp_pkg::entry_t entry_i,
  output logic             pop_o,
  qetp_out_if.source       out_o
);
  import qetp_pkg::*;

  logic out_vld_q, out_vld_d;
  res_t out_res_q, out_res_d;
  logic out_last_q, out_last_d;
  logic sec_pend_q, sec_pend_d;
  res_t sec_res_q, sec_res_d;
  logic load_ok;

  assign load_ok = !out_vld_q || out_o.ready;
  assign pop_o   = load_ok && !sec_pend_q && vld_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_res_d  = out_res_q;
    out_last_d = out_last_q;
    sec_pend_d = sec_pend_q;
    sec_res_d  = sec_res_q;
    if (load_ok) begin
      if (sec_pend_q) begin
        out_vld_d  = 1'b1;
        out_res_d  = sec_res_q;
        out_last_d = 1'b1;
        sec_pend_d = 1'b0;
      end else if (vld_i) begin
        out_vld_d  = 1'b1;
        out_res_d  = entry_i.r0;
        out_last_d = !entry_i.two;
        sec_pend_d = entry_i.two;
        sec_res_d  = entry_i.r1;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
    sec_res_q  <= sec_res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      sec_pend_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      sec_pend_q <= sec_pend_d;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.data   = out_res_q.data;
  assign out_o.status = out_res_q.status;
  assign out_o.last   = out_last_q;

  `QETP_ASSERT(a_sec_held, sec_pend_q |-> out_vld_q)
  `QETP_ASSERT(a_sec_not_last, sec_pend_q |-> !out_last_q)
  `QETP_ASSERT(a_data_only_byte, (out_vld_q && out_res_q.status != ST_BYTE) |-> (out_res_q.data == '0))

endmodule

// ===== test/tb_quoted_escape_token_parser.sv =====
// Testbench for quoted_escape_token_parser: streams command lines in, one character per request,
// and checks every result against a behavioural model held in a small scoreboard class.
// Depends on qetp_pkg, the qetp_in_if/qetp_out_if channels and the parser RTL.
module tb_quoted_escape_token_parser;
  import qetp_pkg::*;

  // Parser modes as the model sees them
  typedef enum logic [2:0] {
    PM_SKIP,       // between tokens, spaces skipped
    PM_TOKEN,      // unquoted segment
    PM_QUOTE,      // inside double quotes
    PM_ESC,        // just seen a backslash
    PM_HEX_FIRST,  // after \x, no digit yet
    PM_HEX,        // collecting hex digits
    PM_OCT,        // collecting octal digits
    PM_DISCARD     // dropping the rest of a failed line
  } parse_mode_e;

  typedef struct packed {
    ch_t     data;
    status_e status;
    logic    last;
  } tok_res_t;

  // Scoreboard: models the tokenizer on every accepted character request and
  // holds the results it should give, oldest first.
  class token_scoreboard;
    parse_mode_e mode;
    logic [7:0]  esc_val;
    logic [1:0]  oct_cnt;
    int unsigned tok_len;
    tok_res_t    awaited[$];
    ch_t         step_data[2];
    status_e     step_stat[2];
    int          n_step;
    int          n_err;

    function new();
      mode    = PM_SKIP;
      esc_val = 8'h00;
      oct_cnt = 2'd0;
      tok_len = 0;
      n_step  = 0;
      n_err   = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void emit(ch_t d, status_e s);
      step_data[n_step] = d;
      step_stat[n_step] = s;
      n_step++;
    endfunction

    function void add_byte(ch_t b);
      emit(b, ST_BYTE);
      tok_len++;
    endfunction

    // Any error voids the token; a NUL that causes it also ends the line.
    function void abort(status_e s, ch_t c);
      emit(8'h00, s);
      mode    = (c == CH_NUL) ? PM_SKIP : PM_DISCARD;
      tok_len = 0;
      esc_val = 8'h00;
      oct_cnt = 2'd0;
    endfunction

    function int hex_digit(ch_t c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
      if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
      return -1;
    endfunction

    function bit is_octal(ch_t c);
      return (c >= CH_ZERO && c <= CH_SEVEN);
    endfunction

    function void in_token(ch_t c);
      if (c == CH_NUL || c == CH_SPACE) begin
        emit(8'h00, ST_TOKEN_END);
        mode    = PM_SKIP;
        tok_len = 0;
      end else if (c == CH_DQUOTE) begin
        mode = PM_QUOTE;
      end else if (tok_len >= MAX_TOKEN_LEN) begin
        abort(ST_TOO_LONG, c);
      end else begin
        add_byte(c);
      end
    endfunction

    // Length is checked at the backslash, so the escape byte is not checked again
    function void in_quote(ch_t c);
      if (c == CH_NUL) begin
        abort(ST_UNCLOSED, c);
      end else if (c == CH_DQUOTE) begin
        mode = PM_TOKEN;
      end else if (tok_len >= MAX_TOKEN_LEN) begin
        abort(ST_TOO_LONG, c);
      end else if (c == CH_BSLASH) begin
        mode = PM_ESC;
      end else begin
        add_byte(c);
      end
    endfunction

    function bit close_escape(ch_t c);
      if (esc_val == 8'h00) begin
        abort(ST_ZERO_ESC, c);
        return 1'b0;
      end
      add_byte(esc_val);
      esc_val = 8'h00;
      oct_cnt = 2'd0;
      mode    = PM_QUOTE;
      return 1'b1;
    endfunction

    function void note_char(ch_t c);
      int h;
      n_step = 0;
      case (mode)
        PM_SKIP: begin
          if (c == CH_NUL) begin
            emit(8'h00, ST_NO_TOKEN);
          end else if (c != CH_SPACE) begin
            tok_len = 0;
            mode    = PM_TOKEN;
            in_token(c);
          end
        end
        PM_TOKEN: in_token(c);
        PM_QUOTE: in_quote(c);
        PM_ESC: begin
          mode = PM_QUOTE;
          case (c)
            CH_NUL:  abort(ST_UNCLOSED, c);
            CH_LO_N: add_byte(8'd10);
            CH_LO_T: add_byte(8'd9);
            CH_LO_R: add_byte(8'd13);
            CH_LO_A: add_byte(8'd7);
            CH_LO_B: add_byte(8'd8);
            CH_LO_F: add_byte(8'd12);
            CH_LO_V: add_byte(8'd11);
            CH_LO_X: begin
              esc_val = 8'h00;
              mode    = PM_HEX_FIRST;
            end
            default: begin
              if (is_octal(c)) begin
                esc_val = {5'd0, c[2:0]};
                oct_cnt = 2'd1;
                mode    = PM_OCT;
              end else begin
                add_byte(c);
              end
            end
          endcase
        end
        PM_HEX_FIRST: begin
          h = hex_digit(c);
          if (h < 0) begin
            abort(ST_EMPTY_HEX, c);
          end else begin
            esc_val = 8'(h);
            mode    = PM_HEX;
          end
        end
        PM_HEX: begin
          h = hex_digit(c);
          if (h >= 0) begin
            esc_val = {esc_val[3:0], 4'(h)};
          end else if (close_escape(c)) begin
            in_quote(c);  // terminating character handled as quoted text
          end
        end
        PM_OCT: begin
          if (is_octal(c)) begin
            esc_val = {esc_val[4:0], c[2:0]};
            oct_cnt++;
            if (oct_cnt == 2'd3) void'(close_escape(c));
          end else if (close_escape(c)) begin
            in_quote(c);
          end
        end
        default: begin
          if (c == CH_NUL) begin
            mode    = PM_SKIP;
            tok_len = 0;
          end
        end
      endcase
      for (int i = 0; i < n_step; i++) begin
        awaited.push_back(tok_res_t'{step_data[i], step_stat[i], (i == n_step - 1)});
      end
    endfunction

    function void fault(string msg);
      $error("%s", msg);
      n_err++;
    endfunction

    function void check_result(ch_t d, logic [2:0] s, logic l);
      tok_res_t e;
      if (awaited.size() == 0) begin
        fault($sformatf("result with none awaited: data=%0h status=%0d last=%0b", d, s, l));
        return;
      end
      e = awaited.pop_front();
      if (d !== e.data)
        fault($sformatf("data: expected %0h, got %0h", e.data, d));
      if (s !== e.status)
        fault($sformatf("status: expected %0d, got %0d", e.status, s));
      if (l !== e.last)
        fault($sformatf("last: expected %0b, got %0b", e.last, l));
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  qetp_in_if  in_if ();
  qetp_out_if out_if ();

  quoted_escape_token_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  token_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned n_sent     = 0;
  int unsigned n_results  = 0;
  ch_t         line_buf[$];

  ch_t esc_letters[7] = '{CH_LO_N, CH_LO_T, CH_LO_R, CH_LO_A, CH_LO_B, CH_LO_F, CH_LO_V};

  // Directed lines, NUL terminated: empty line, 0xFF token, empty quotes "",
  // backslash at end of line, \x with no digit, zero escape \0, and a hex
  // escape closed by an ordinary character (two results from one request).
  ch_t directed_chars[27] = '{
    CH_NUL,
    8'hFF, CH_NUL,
    CH_DQUOTE, CH_DQUOTE, CH_NUL,
    CH_DQUOTE, CH_BSLASH, CH_NUL,
    CH_DQUOTE, CH_BSLASH, CH_LO_X, CH_DQUOTE, CH_NUL,
    CH_DQUOTE, CH_BSLASH, CH_ZERO, CH_DQUOTE, CH_NUL,
    CH_DQUOTE, CH_BSLASH, CH_LO_X, 8'h34, 8'h31, 8'h7A, CH_DQUOTE, CH_NUL
  };

  // ---------------------------------------------------------------------------
  // Line generation
  // ---------------------------------------------------------------------------

  // Any non-NUL character that does not end or open a segment; inside quotes
  // the backslash is kept out too so escapes only come from the escape picker.
  function automatic ch_t text_char(bit quoted);
    ch_t c;
    do begin
      case ($urandom_range(0, 3))
        0:       c = ch_t'($urandom_range(8'h01, 8'h1F));
        1, 2:    c = ch_t'($urandom_range(8'h21, 8'h7E));
        default: c = ch_t'($urandom_range(8'h7F, 8'hFF));
      endcase
    end while (c == CH_DQUOTE || (quoted && c == CH_BSLASH));
    return c;
  endfunction

  function automatic ch_t hex_char(int unsigned v);
    if (v < 10) return ch_t'(CH_ZERO + v);
    return ch_t'(($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + v - 10);
  endfunction

  // Noise leans on the characters that steer the parser
  function automatic ch_t noise_char();
    case ($urandom_range(0, 7))
      0:       return CH_SPACE;
      1:       return CH_DQUOTE;
      2:       return CH_BSLASH;
      3:       return CH_LO_X;
      4:       return ch_t'(CH_ZERO + $urandom_range(0, 7));
      default: return ch_t'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic void add_spaces(int unsigned n);
    repeat (n) line_buf.push_back(CH_SPACE);
  endfunction

  function automatic void add_quoted();
    int unsigned n_dig;
    line_buf.push_back(CH_DQUOTE);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0, 1: line_buf.push_back(text_char(1'b1));
        2: begin
          line_buf.push_back(CH_BSLASH);
          line_buf.push_back(esc_letters[$urandom_range(0, 6)]);
        end
        3: begin
          // \x with one to three digits, now and then none at all
          n_dig = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
          line_buf.push_back(CH_BSLASH);
          line_buf.push_back(CH_LO_X);
          repeat (n_dig) line_buf.push_back(hex_char($urandom_range(0, 15)));
        end
        4: begin
          line_buf.push_back(CH_BSLASH);
          repeat ($urandom_range(1, 3)) line_buf.push_back(ch_t'(CH_ZERO + $urandom_range(0, 7)));
        end
        default: begin
          line_buf.push_back(CH_BSLASH);
          line_buf.push_back(text_char(1'b0));
        end
      endcase
    end
    line_buf.push_back(CH_DQUOTE);
  endfunction

  // u unquoted bytes, then optionally q quoted bytes closed by \n and a quote
  function automatic void add_long_token(int unsigned u, int unsigned q);
    repeat (u) line_buf.push_back(text_char(1'b0));
    if (q != 0) begin
      line_buf.push_back(CH_DQUOTE);
      repeat (q) line_buf.push_back(text_char(1'b1));
      line_buf.push_back(CH_BSLASH);
      line_buf.push_back(CH_LO_N);
      line_buf.push_back(CH_DQUOTE);
    end
  endfunction

  function automatic void build_line(int unsigned line_no);
    int unsigned kind;
    int unsigned cut;
    line_buf.delete();
    if (line_no % 12 == 5) begin
      // Length limit, cycled: over-long unquoted, limit hit at the backslash,
      // escape landing on the last allowed byte, exactly the limit unquoted.
      case ((line_no / 12) % 4)
        0:       add_long_token(260, 0);
        1:       add_long_token(127, 128);
        2:       add_long_token(127, 127);
        default: add_long_token(255, 0);
      endcase
    end else begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        repeat ($urandom_range(0, 16)) line_buf.push_back(noise_char());
      end else begin
        add_spaces($urandom_range(0, 2));
        repeat ($urandom_range(1, 4)) begin
          if (line_buf.size() != 0 && line_buf[$] != CH_SPACE) add_spaces($urandom_range(1, 2));
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 1)) add_quoted();
            else repeat ($urandom_range(1, 6)) line_buf.push_back(text_char(1'b0));
          end
        end
        add_spaces($urandom_range(0, 2));
        // Broken line: chopped short, so quotes and escapes hit end of line
        if (kind < 4 && line_buf.size() > 1) begin
          cut = $urandom_range(1, line_buf.size() - 1);
          while (line_buf.size() > cut) void'(line_buf.pop_back());
        end
      end
    end
    line_buf.push_back(CH_NUL);
  endfunction

  // ---------------------------------------------------------------------------
  // Character request driver
  // ---------------------------------------------------------------------------

  // Bursts of random length with random gaps; long bursts give stretches
  // with no idling at all.
  task automatic send_char(input ch_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 32);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_char(c);
    burst_left--;
    n_sent++;
  endtask

  // Stop offering and wait for every awaited result; always waits on the clock
  // first so valid is not lowered and raised in the same step.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned line_no;
    in_if.valid <= 1'b0;
    in_if.ch    <= CH_NUL;
    line_no = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_chars[i]) send_char(directed_chars[i]);
    wait_drained();

    // Random lines: mostly well-formed with random content, some noise and
    // chopped lines; one mid-run pause until the output side has caught up.
    while (n_sent < 1800) begin
      build_line(line_no);
      foreach (line_buf[i]) send_char(line_buf[i]);
      if (line_no == 40) wait_drained();
      line_no++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("tb_quoted_escape_token_parser: PASS");
    end else begin
      $display("tb_quoted_escape_token_parser: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result receiver
  // ---------------------------------------------------------------------------

  // Ready follows stretches of its own: always ready, coin toss, mostly
  // ready, one in four. Once, after 150 results, it holds off while
  // requests keep coming, so the result queue fills and input stalls.
  initial begin : result_sink
    int unsigned stretch_left;
    int unsigned ready_kind;
    bit          long_hold_done;
    out_if.ready <= 1'b0;
    stretch_left   = 0;
    ready_kind     = 0;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.data, out_if.status, out_if.last);
        n_results++;
      end
      if (!long_hold_done && n_results >= 150) begin
        long_hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end else begin
        if (stretch_left == 0) begin
          ready_kind   = $urandom_range(0, 3);
          stretch_left = $urandom_range(4, 60);
        end
        stretch_left--;
        case (ready_kind)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 1) == 1);
          2:       out_if.ready <= ($urandom_range(0, 9) != 0);
          default: out_if.ready <= (stretch_left % 4 == 0);
        endcase
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("tb_quoted_escape_token_parser: FAIL");
    $finish;
  end

endmodule
